[rtl/bspline_surface_point_eval_assert.svh]
// Assertion macros for the B-spline surface evaluator.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef BSPLINE_SURFACE_POINT_EVAL_ASSERT_SVH
`define BSPLINE_SURFACE_POINT_EVAL_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked outside reset.
`define BSPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define BSPE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BSPE_ASSERT(lbl, prop, msg)
`define BSPE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/bspe_pkg.sv]
// Shared constants, payload types and control structs of the B-spline surface evaluator.
// No dependencies.
`timescale 1ns / 1ps
package bspe_pkg;

    localparam int C_DEGREE   = 3;
    localparam int C_PPS      = 6;
    localparam int C_COORD_W  = 16;
    localparam int C_PFB      = 12;
    localparam int C_PARAM_W  = C_PFB + 2;
    localparam int C_IDX_IN_W = 6;
    localparam int C_BFRAC    = 24;
    localparam int C_BW       = C_BFRAC + 1;
    localparam int C_NPTS     = C_PPS * C_PPS;
    localparam int C_NKS      = C_PPS + C_DEGREE;
    localparam int C_TOP      = C_PPS - C_DEGREE;
    localparam int C_KB       = $clog2(C_TOP + 1);
    localparam int C_DMW      = C_PFB + C_KB;
    localparam int C_DSW      = ((C_DMW > C_PARAM_W) ? C_DMW : C_PARAM_W) + 1;
    localparam int C_QW       = C_DMW + C_BW - C_PFB;
    localparam int C_RS       = C_QW + 3;
    localparam int C_RW       = C_RS + 1;
    localparam int C_SPAN_W   = $clog2(C_NKS);
    localparam int C_BADDR_W  = $clog2(2 * C_NKS);
    localparam int C_SADDR_W  = $clog2(C_NPTS);
    localparam int C_LVL_W    = $clog2(C_DEGREE + 1);
    localparam int C_WIN_W    = $clog2(C_DEGREE + 1);
    localparam int C_ACC_W    = C_BFRAC + 1 + C_COORD_W + 2 * C_WIN_W + 1;
    localparam int C_DRAIN    = 3;
    localparam int C_DRAIN_W  = 2;

    localparam logic [C_RW-1:0] C_RECIP3 = C_RW'(((64'd1 << C_RS) + 64'd2) / 64'd3);
    localparam logic [C_RW-1:0] C_RECIP5 = C_RW'(((64'd1 << C_RS) + 64'd4) / 64'd5);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic                        opcode;
        logic [C_IDX_IN_W-1:0]       point_index;
        logic signed [C_COORD_W-1:0] point_x;
        logic signed [C_COORD_W-1:0] point_y;
        logic signed [C_COORD_W-1:0] point_z;
        logic [C_PARAM_W-1:0]        param_u;
        logic [C_PARAM_W-1:0]        param_v;
    } t_in_item;

    typedef struct packed {
        logic signed [C_COORD_W-1:0] surf_x;
        logic signed [C_COORD_W-1:0] surf_y;
        logic signed [C_COORD_W-1:0] surf_z;
        logic                        out_of_domain;
    } t_out_item;

    typedef struct packed {
        logic                capture;
        logic                load_we;
        logic                init_we;
        logic                term_valid;
        logic                term_side;
        logic                dir;
        logic [C_LVL_W-1:0]  lvl;
        logic [C_SPAN_W-1:0] idx;
        logic                mac_valid;
        logic [C_WIN_W-1:0]  rr;
        logic [C_WIN_W-1:0]  cc;
        logic                finish;
    } t_dp_cmd;

    typedef struct packed {
        logic ood;
        logic out_free;
    } t_dp_sts;

    // Clamped uniform knot vector.
    function automatic logic [C_KB-1:0] knot_at(input int k);
        logic [C_KB-1:0] res;
        if (k <= C_DEGREE) begin
            res = '0;
        end else if (k >= C_PPS) begin
            res = C_KB'(C_TOP);
        end else begin
            res = C_KB'(k - C_DEGREE);
        end
        return res;
    endfunction

    function automatic logic [C_DSW-1:0] knot_shifted(input int k);
        return C_DSW'(knot_at(k)) << C_PFB;
    endfunction

    // Ceiling reciprocal of a knot span, exact for quotients below 2^C_QW.
    function automatic logic [C_RW-1:0] recip_of(input logic [C_KB-1:0] den);
        logic [C_RW-1:0] res;
        res = '0;
        if (int'(den) == 1) res = C_RW'(1) << C_RS;
        if (int'(den) == 2) res = C_RW'(1) << (C_RS - 1);
        if (int'(den) == 3) res = C_RECIP3;
        if (int'(den) == 4) res = C_RW'(1) << (C_RS - 2);
        if (int'(den) == 5) res = C_RECIP5;
        return res;
    endfunction

endpackage

[rtl/bspe_ctrl.sv]
// Sequencer of the B-spline surface evaluator: basis recursion, MAC window, result hand-off.
// Depends on bspe_pkg and bspline_surface_point_eval_assert.svh.
`timescale 1ns / 1ps
`include "bspline_surface_point_eval_assert.svh"
module bspe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    output logic              o_in_ready,
    input  bspe_pkg::t_dp_sts i_sts,
    output bspe_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_TERM   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_MAC    = 7'b0010000,
        S_MDRAIN = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state                               r_state, n_state;
    logic                                 r_dir, n_dir;
    logic                                 r_side, n_side;
    logic [bspe_pkg::C_LVL_W-1:0]         r_lvl, n_lvl;
    logic [bspe_pkg::C_SPAN_W-1:0]        r_idx, n_idx;
    logic [bspe_pkg::C_WIN_W-1:0]         r_rr, n_rr;
    logic [bspe_pkg::C_WIN_W-1:0]         r_cc, n_cc;
    logic [bspe_pkg::C_DRAIN_W-1:0]       r_cnt, n_cnt;
    logic                                 accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = accept && (i_opcode == bspe_pkg::OP_EVAL);
        o_cmd.load_we    = accept && (i_opcode == bspe_pkg::OP_LOAD);
        o_cmd.init_we    = (r_state == S_INIT) && !i_sts.ood;
        o_cmd.term_valid = (r_state == S_TERM);
        o_cmd.term_side  = r_side;
        o_cmd.dir        = r_dir;
        o_cmd.lvl        = r_lvl;
        o_cmd.idx        = r_idx;
        o_cmd.mac_valid  = (r_state == S_MAC);
        o_cmd.rr         = r_rr;
        o_cmd.cc         = r_cc;
        o_cmd.finish     = (r_state == S_FINISH) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_dir   = r_dir;
        n_side  = r_side;
        n_lvl   = r_lvl;
        n_idx   = r_idx;
        n_rr    = r_rr;
        n_cc    = r_cc;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == bspe_pkg::OP_EVAL)) begin
                    n_state = S_INIT;
                    n_dir   = 1'b0;
                    n_idx   = '0;
                end
            end
            S_INIT: begin
                if (i_sts.ood) begin
                    n_state = S_FINISH;
                end else if (int'(r_idx) == bspe_pkg::C_NKS - 1) begin
                    n_state = S_TERM;
                    n_lvl   = bspe_pkg::C_LVL_W'(1);
                    n_idx   = '0;
                    n_side  = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TERM: begin
                n_side = !r_side;
                if (r_side) begin
                    if (int'(r_idx) + int'(r_lvl) == bspe_pkg::C_NKS - 1) begin
                        n_state = S_DRAIN;
                        n_cnt   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (int'(r_cnt) == bspe_pkg::C_DRAIN - 1) begin
                    if (int'(r_lvl) == bspe_pkg::C_DEGREE) begin
                        if (!r_dir) begin
                            n_dir   = 1'b1;
                            n_idx   = '0;
                            n_state = S_INIT;
                        end else begin
                            n_rr    = '0;
                            n_cc    = '0;
                            n_state = S_MAC;
                        end
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_idx   = '0;
                        n_side  = 1'b0;
                        n_state = S_TERM;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAC: begin
                if (int'(r_cc) == bspe_pkg::C_DEGREE) begin
                    n_cc = '0;
                    if (int'(r_rr) == bspe_pkg::C_DEGREE) begin
                        n_state = S_MDRAIN;
                        n_cnt   = '0;
                    end else begin
                        n_rr = r_rr + 1'b1;
                    end
                end else begin
                    n_cc = r_cc + 1'b1;
                end
            end
            S_MDRAIN: begin
                if (int'(r_cnt) == bspe_pkg::C_DRAIN - 1) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= 1'b0;
            r_side  <= 1'b0;
            r_lvl   <= '0;
            r_idx   <= '0;
            r_rr    <= '0;
            r_cc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_side  <= n_side;
            r_lvl   <= n_lvl;
            r_idx   <= n_idx;
            r_rr    <= n_rr;
            r_cc    <= n_cc;
            r_cnt   <= n_cnt;
        end
    end

    `BSPE_ASSERT(a_finish_needs_room, o_cmd.finish |-> i_sts.out_free, "result issued into full output")
    `BSPE_ASSERT(a_eval_starts_init, o_cmd.capture |=> (r_state == S_INIT), "evaluate did not start")
    `BSPE_ASSERT(a_finish_frees_input, o_cmd.finish |=> o_in_ready, "input not reopened after result")
    `BSPE_ASSERT_RST(a_reset_to_idle, !i_rst_n |=> (r_state == S_IDLE), "reset did not reach idle")

endmodule

[rtl/bspe_dpath.sv]
// Datapath of the B-spline surface evaluator: control store, basis memory,
// recursion pipeline, weighted MAC and output register. Depends on bspe_pkg.
`timescale 1ns / 1ps
module bspe_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bspe_pkg::t_dp_cmd   i_cmd,
    input  bspe_pkg::t_in_item  i_in_item,
    output bspe_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bspe_pkg::t_out_item o_out_item
);

    localparam int PW   = bspe_pkg::C_PARAM_W;
    localparam int CW   = bspe_pkg::C_COORD_W;
    localparam int BW   = bspe_pkg::C_BW;
    localparam int AW   = bspe_pkg::C_BADDR_W;
    localparam int SW   = bspe_pkg::C_SADDR_W;
    localparam int DSW  = bspe_pkg::C_DSW;
    localparam int DMW  = bspe_pkg::C_DMW;
    localparam int KB   = bspe_pkg::C_KB;
    localparam int QW   = bspe_pkg::C_QW;
    localparam int RW   = bspe_pkg::C_RW;
    localparam int ACW  = bspe_pkg::C_ACC_W;
    localparam int PRW  = BW + 1 + CW;
    localparam int RNW  = ACW - bspe_pkg::C_BFRAC;
    localparam int TOP_P = bspe_pkg::C_TOP << bspe_pkg::C_PFB;
    localparam logic signed [RNW-1:0] MAXR = RNW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [RNW-1:0] MINR = ~MAXR;

    // ---- latched parameters ----
    logic [PW-1:0] r_u, r_v;
    logic          ood;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u <= i_in_item.param_u;
            r_v <= i_in_item.param_v;
        end
    end

    assign ood = (int'(r_u) >= TOP_P) || (int'(r_v) >= TOP_P);

    // ---- issue stage: knot distances and addresses ----
    logic [PW-1:0]           sel_p;
    logic [KB-1:0]           ka, kb, den;
    logic signed [DSW-1:0]   p_ext, kas, kbs, dist_s, k0s, k1s;
    logic                    dist_pos, in_span;
    logic [AW-1:0]           base, term_addr, cu, cv, rd_addr_a, rd_addr_b;
    logic [SW-1:0]           saddr;

    always_comb begin
        sel_p    = i_cmd.dir ? r_v : r_u;
        ka       = bspe_pkg::knot_at(int'(i_cmd.idx) + int'(i_cmd.term_side));
        kb       = bspe_pkg::knot_at(int'(i_cmd.idx) + int'(i_cmd.lvl) + int'(i_cmd.term_side));
        kas      = bspe_pkg::knot_shifted(int'(i_cmd.idx) + int'(i_cmd.term_side));
        kbs      = bspe_pkg::knot_shifted(int'(i_cmd.idx) + int'(i_cmd.lvl)
                                          + int'(i_cmd.term_side));
        den      = kb - ka;
        p_ext    = DSW'(sel_p);
        dist_s   = i_cmd.term_side ? (kbs - p_ext) : (p_ext - kas);
        dist_pos = !dist_s[DSW-1] && (dist_s != '0);
        k0s      = bspe_pkg::knot_shifted(int'(i_cmd.idx));
        k1s      = bspe_pkg::knot_shifted(int'(i_cmd.idx) + 1);
        in_span  = (k0s <= p_ext) && (p_ext < k1s);
        base      = i_cmd.dir ? AW'(bspe_pkg::C_NKS) : '0;
        term_addr = base + AW'(i_cmd.idx) + AW'(i_cmd.term_side);
        cu        = AW'(r_u[PW-1:bspe_pkg::C_PFB]) + AW'(i_cmd.cc);
        cv        = AW'(r_v[PW-1:bspe_pkg::C_PFB]) + AW'(i_cmd.rr);
        rd_addr_a = i_cmd.term_valid ? term_addr : cu;
        rd_addr_b = AW'(bspe_pkg::C_NKS) + cv;
        saddr     = SW'((int'(r_v[PW-1:bspe_pkg::C_PFB]) + int'(i_cmd.rr)) * bspe_pkg::C_PPS
                        + int'(r_u[PW-1:bspe_pkg::C_PFB]) + int'(i_cmd.cc));
    end

    // ---- recursion pipeline ----
    logic                         r_t0_valid, r_t1_valid, r_t2_valid;
    logic                         r_t0_side, r_t1_side, r_t2_side;
    logic                         r_t0_dir, r_t1_dir, r_t2_dir;
    logic [bspe_pkg::C_SPAN_W-1:0] r_t0_idx, r_t1_idx, r_t2_idx;
    logic [KB-1:0]                r_t0_den;
    logic                         r_t0_pos, r_t1_ok, r_t2_ok;
    logic [DMW-1:0]               r_t0_dist;
    logic [DMW+BW-1:0]            r_t1_prod;
    logic [RW-1:0]                r_t1_recip;
    logic [QW+RW-1:0]             r_t2_prod;
    logic [BW-1:0]                r_left, term;
    logic [BW-1:0]                r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_valid <= 1'b0;
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
        end else begin
            r_t0_valid <= i_cmd.term_valid;
            r_t1_valid <= r_t0_valid;
            r_t2_valid <= r_t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0_side  <= i_cmd.term_side;
        r_t0_dir   <= i_cmd.dir;
        r_t0_idx   <= i_cmd.idx;
        r_t0_den   <= den;
        r_t0_pos   <= dist_pos;
        r_t0_dist  <= dist_s[DMW-1:0];
        r_t1_side  <= r_t0_side;
        r_t1_dir   <= r_t0_dir;
        r_t1_idx   <= r_t0_idx;
        r_t1_ok    <= (r_rd_a != '0) && (r_t0_den != '0) && r_t0_pos;
        r_t1_prod  <= r_t0_dist * r_rd_a;
        r_t1_recip <= bspe_pkg::recip_of(r_t0_den);
        r_t2_side  <= r_t1_side;
        r_t2_dir   <= r_t1_dir;
        r_t2_idx   <= r_t1_idx;
        r_t2_ok    <= r_t1_ok;
        r_t2_prod  <= r_t1_prod[DMW+BW-1:bspe_pkg::C_PFB] * r_t1_recip;
        if (r_t2_valid && !r_t2_side) begin
            r_left <= term;
        end
    end

    assign term = r_t2_ok ? r_t2_prod[bspe_pkg::C_RS +: BW] : '0;

    // ---- basis memory: one write port, two registered read ports ----
    logic [BW-1:0] r_basis [0:2*bspe_pkg::C_NKS-1];
    logic          bw_en;
    logic [AW-1:0] bw_addr;
    logic [BW-1:0] bw_data;

    always_comb begin
        bw_en = i_cmd.init_we || (r_t2_valid && r_t2_side);
        if (i_cmd.init_we) begin
            bw_addr = base + AW'(i_cmd.idx);
            bw_data = in_span ? (BW'(1) << bspe_pkg::C_BFRAC) : '0;
        end else begin
            bw_addr = (r_t2_dir ? AW'(bspe_pkg::C_NKS) : '0) + AW'(r_t2_idx);
            bw_data = r_left + term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bw_en) begin
            r_basis[bw_addr] <= bw_data;
        end
        r_rd_a <= r_basis[rd_addr_a];
        r_rd_b <= r_basis[rd_addr_b];
    end

    // ---- control point store ----
    logic [3*CW-1:0] r_store [0:bspe_pkg::C_NPTS-1];
    logic [3*CW-1:0] r_store_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (int'(i_in_item.point_index) < bspe_pkg::C_NPTS)) begin
            r_store[i_in_item.point_index[SW-1:0]] <= {i_in_item.point_x,
                                                       i_in_item.point_y,
                                                       i_in_item.point_z};
        end
        r_store_rd <= r_store[saddr];
    end

    // ---- weighted accumulate ----
    logic                     r_m0_valid, r_m1_valid, r_m2_valid;
    logic [2*BW-1:0]          w_full;
    logic [BW-1:0]            r_m1_w;
    logic [3*CW-1:0]          r_m1_pt;
    logic signed [BW:0]       w_s;
    logic signed [CW-1:0]     coord [3];
    logic signed [PRW-1:0]    m_prod [3];
    logic signed [PRW-1:0]    r_m2_p [3];
    logic signed [ACW-1:0]    r_acc [3];

    assign w_full = r_rd_a * r_rd_b;
    assign w_s    = {1'b0, r_m1_w};

    always_comb begin
        coord[0] = r_m1_pt[3*CW-1:2*CW];
        coord[1] = r_m1_pt[2*CW-1:CW];
        coord[2] = r_m1_pt[CW-1:0];
        for (int k = 0; k < 3; k++) begin
            m_prod[k] = w_s * coord[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_valid <= 1'b0;
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else begin
            r_m0_valid <= i_cmd.mac_valid;
            r_m1_valid <= r_m0_valid;
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_w  <= w_full[bspe_pkg::C_BFRAC +: BW];
        r_m1_pt <= r_store_rd;
        for (int k = 0; k < 3; k++) begin
            // zero weight drops the point, whatever the slot holds
            r_m2_p[k] <= (r_m1_w == '0) ? '0 : m_prod[k];
            if (i_cmd.capture) begin
                r_acc[k] <= '0;
            end else if (r_m2_valid) begin
                r_acc[k] <= r_acc[k] + ACW'(r_m2_p[k]);
            end
        end
    end

    // ---- round half up and saturate ----
    function automatic logic signed [CW-1:0] round_sat(input logic signed [ACW-1:0] acc);
        logic [ACW-1:0]        t;
        logic signed [RNW-1:0] r;
        logic signed [CW-1:0]  res;
        t = acc + (ACW'(1) << (bspe_pkg::C_BFRAC - 1));
        r = t[ACW-1:bspe_pkg::C_BFRAC];
        if (r > MAXR) begin
            res = MAXR[CW-1:0];
        end else if (r < MINR) begin
            res = MINR[CW-1:0];
        end else begin
            res = r[CW-1:0];
        end
        return res;
    endfunction

    // ---- output register ----
    logic r_out_valid;
    bspe_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.out_of_domain <= ood;
            r_out.surf_x        <= ood ? '0 : round_sat(r_acc[0]);
            r_out.surf_y        <= ood ? '0 : round_sat(r_acc[1]);
            r_out.surf_z        <= ood ? '0 : round_sat(r_acc[2]);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;
    assign o_sts.ood      = ood;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

[rtl/bspline_surface_point_eval.sv]
// Top level of the B-spline surface evaluator: sequencer plus datapath.
// Depends on bspe_pkg, bspe_ctrl and bspe_dpath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | into core | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | from core | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// A load transaction writes the store on acceptance.
// An evaluate runs through the shared basis pipeline twice (u, then v): per
// direction NKS init writes plus, per degree level q, 2*(NKS-q) terms and a
// drain; then (DEGREE+1)^2 MAC issues, a drain and the result write. An
// out-of-domain evaluate goes from init straight to the result write. No new
// transaction is accepted until an evaluate has written its result.
// Reset is synchronous, active low; the store has no reset and must be loaded.
// A result waiting in the output register does not block the next load or
// evaluate; only the write of the next result stalls until the output frees.
`timescale 1ns / 1ps
module bspline_surface_point_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bspe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bspe_pkg::t_out_item o_out_item
);

    // Command and status between sequencer and datapath.
    bspe_pkg::t_dp_cmd cmd;
    bspe_pkg::t_dp_sts sts;

    // Sequencer: accepts transactions, steps the recursion and MAC window.
    bspe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: store, basis memory, pipelines and output register.
    bspe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[verif/tb_bspline_surface_point_eval.sv]
// Self-checking testbench for the B-spline surface evaluator: loads control points,
// evaluates (u,v) points and compares each result with an in-bench fixed-point predictor.
// Depends on bspe_pkg and bspline_surface_point_eval.
`timescale 1ns / 1ps
module tb_bspline_surface_point_eval;

    localparam int NSIDE     = 6;
    localparam int DEG       = 3;
    localparam int NSPANS    = NSIDE + DEG;
    localparam int PFRAC     = 12;
    localparam int WFRAC     = 24;
    localparam int TOP_PARAM = (NSIDE - DEG) << PFRAC;
    localparam int NSLOTS    = NSIDE * NSIDE;
    localparam int STALL_LIMIT = 20000;
    // Tail wait after the last test, with margin beyond one evaluate.
    localparam int TAIL_CYCLES = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    bspe_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    bspe_pkg::t_out_item o_out_item;

    bspline_surface_point_eval DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Predictor state: shadow copy of the control store.
    logic signed [15:0]  shadow_pts[NSLOTS][3];
    bspe_pkg::t_out_item surf_expected[$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  hold_off;
    int                  idle_cycles;

    function automatic longint knot_pos(input int k);
        if (k <= DEG) return 0;
        if (k >= NSIDE) return NSIDE - DEG;
        return k - DEG;
    endfunction

    // Cox-de Boor basis values with 24 fraction bits.
    function automatic void basis_weights(input longint prm, output longint nb[NSPANS]);
        longint lo, hi, den, reach, acc;
        for (int i = 0; i < NSPANS; i++) begin
            lo = knot_pos(i) << PFRAC;
            hi = knot_pos(i + 1) << PFRAC;
            nb[i] = (lo <= prm && prm < hi) ? (64'sd1 <<< WFRAC) : 0;
        end
        for (int q = 1; q <= DEG; q++) begin
            for (int i = 0; i + q < NSPANS; i++) begin
                acc = 0;
                den = knot_pos(i + q) - knot_pos(i);
                reach = prm - (knot_pos(i) << PFRAC);
                if (nb[i] != 0 && den > 0 && reach > 0)
                    acc += (reach * nb[i]) / (den << PFRAC);
                den = knot_pos(i + q + 1) - knot_pos(i + 1);
                reach = (knot_pos(i + q + 1) << PFRAC) - prm;
                if (nb[i + 1] != 0 && den > 0 && reach > 0)
                    acc += (reach * nb[i + 1]) / (den << PFRAC);
                nb[i] = acc;
            end
        end
    endfunction

    function automatic logic signed [15:0] round_saturate(input longint acc);
        longint r;
        r = (acc + (64'sd1 <<< (WFRAC - 1))) >>> WFRAC;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // Apply one accepted load to the shadow store, or queue the expected result of an evaluate.
    task automatic predict_surface(input bspe_pkg::t_in_item it);
        longint              nu[NSPANS], nv[NSPANS];
        longint              acc[3];
        longint              w;
        bspe_pkg::t_out_item res;
        if (it.opcode == bspe_pkg::OP_LOAD) begin
            if (it.point_index < NSLOTS) begin
                shadow_pts[it.point_index][0] = it.point_x;
                shadow_pts[it.point_index][1] = it.point_y;
                shadow_pts[it.point_index][2] = it.point_z;
            end
            return;
        end
        res = '0;
        if (it.param_u >= TOP_PARAM || it.param_v >= TOP_PARAM) begin
            res.out_of_domain = 1'b1;
        end else begin
            basis_weights(longint'(it.param_u), nu);
            basis_weights(longint'(it.param_v), nv);
            acc = '{0, 0, 0};
            for (int r = 0; r < NSIDE; r++) begin
                for (int c = 0; c < NSIDE; c++) begin
                    if (nv[r] != 0 && nu[c] != 0) begin
                        w = (nu[c] * nv[r]) >>> WFRAC;
                        for (int k = 0; k < 3; k++)
                            acc[k] += w * longint'(shadow_pts[r * NSIDE + c][k]);
                    end
                end
            end
            res.surf_x = round_saturate(acc[0]);
            res.surf_y = round_saturate(acc[1]);
            res.surf_z = round_saturate(acc[2]);
        end
        surf_expected.push_back(res);
    endtask

    // Offer one transaction and hold it until the block takes it.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input bspe_pkg::t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_surface(it);
        @(negedge i_clk);
    endtask

    function automatic bspe_pkg::t_in_item load_item(input int slot, input logic [15:0] x,
                                                     input logic [15:0] y,
                                                     input logic [15:0] z);
        bspe_pkg::t_in_item it;
        logic [95:0]        raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(bspe_pkg::t_in_item)-1:0];
        it.opcode = bspe_pkg::OP_LOAD;
        it.point_index = 6'(slot);
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    function automatic bspe_pkg::t_in_item eval_item(input int u, input int v);
        bspe_pkg::t_in_item it;
        logic [95:0]        raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(bspe_pkg::t_in_item)-1:0];
        it.opcode = bspe_pkg::OP_EVAL;
        it.param_u = 14'(u);
        it.param_v = 14'(v);
        return it;
    endfunction

    // Mostly in-domain parameters, a few at or past the top knot.
    function automatic int rand_param();
        case ($urandom_range(9, 0))
            0: return $urandom_range(16383, TOP_PARAM);
            1: return $urandom_range(1, 0) ? 0 : TOP_PARAM - 1;
            default: return $urandom_range(TOP_PARAM - 1, 0);
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5, 0))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (surf_expected.size() != 0);
    endtask

    task automatic test_load_all_extremes();
        for (int s = 0; s < NSLOTS; s++)
            send_item(load_item(s, (s % 2) ? 16'h7fff : 16'h8000, 16'h7fff, 16'h8000));
        // Slot past the grid: dropped by the block.
        send_item(load_item(63, 16'h1234, 16'h5678, 16'h9abc));
    endtask

    task automatic test_directed_evaluate();
        send_item(eval_item(0, 0));
        send_item(eval_item(TOP_PARAM - 1, TOP_PARAM - 1));
        send_item(eval_item(TOP_PARAM, 0));
        send_item(eval_item(0, TOP_PARAM));
        send_item(eval_item(16383, 16383));
        send_item(eval_item(4096, 8192));
        send_item(eval_item(2048, 10000));
        send_item(eval_item(1, 12287));
        send_item(load_item(14, 16'h0000, 16'hffff, 16'h0001));
        send_item(eval_item(5000, 5000));
    endtask

    task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(2, 0) == 0)
                send_item(load_item($urandom_range(63, 0), rand_coord(), rand_coord(),
                                    rand_coord()));
            else
                send_item(eval_item(rand_param(), rand_param()));
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while evaluates keep coming.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        for (int n = 0; n < 6; n++)
            send_item(eval_item(rand_param(), rand_param()));
        drain_results();
        wait (hold_off == 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (hold_off) begin
            repeat (3000) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Receiver: random stalls, change at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        bspe_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (surf_expected.size() == 0) begin
                $error("result with no evaluate outstanding: %h", o_out_item);
                error_count++;
            end else begin
                want = surf_expected.pop_front();
                if (o_out_item.surf_x !== want.surf_x) begin
                    $error("surf_x expected %0d got %0d", want.surf_x, o_out_item.surf_x);
                    error_count++;
                end
                if (o_out_item.surf_y !== want.surf_y) begin
                    $error("surf_y expected %0d got %0d", want.surf_y, o_out_item.surf_y);
                    error_count++;
                end
                if (o_out_item.surf_z !== want.surf_z) begin
                    $error("surf_z expected %0d got %0d", want.surf_z, o_out_item.surf_z);
                    error_count++;
                end
                if (o_out_item.out_of_domain !== want.out_of_domain) begin
                    $error("out_of_domain expected %0b got %0b", want.out_of_domain,
                           o_out_item.out_of_domain);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_load_all_extremes();
        test_directed_evaluate();
        drain_results();
        test_backpressure();
        test_random_mix(450, 0, 0);
        test_random_mix(400, 62, 0);
        test_random_mix(400, 0, 62);
        test_random_mix(400, 15, 15);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && surf_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
